// ===== rtl/core/capu_pkg.sv =====
// ----------------------------------------------------------------------------
// capu_pkg
// Shared types, constants and sequencer step codes for the cascaded
// two-axis attitude PI controller.
// ----------------------------------------------------------------------------
package capu_pkg;

  localparam int ANGLE_W = 16;
  localparam int GAIN_W  = 24;
  localparam int LIMIT_W = 23;
  localparam int CFG_IDX_W = 3;

  // gain fraction bits; outer loop output is taken at this bit position
  localparam int GainFracBits = 16;
  localparam int OuterHi      = GainFracBits + 32;

  // multiplier operand and product widths
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 25;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // low-pass weights (Q0.16) and gyro scale (Q0.16)
  localparam logic signed [MUL_B_W-1:0] LP_OLD_W   = 25'sd55706;
  localparam logic signed [MUL_B_W-1:0] LP_NEW_W   = 25'sd9830;
  localparam logic signed [MUL_B_W-1:0] RATE_SCALE = 25'sd4000;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH_ANGLE_KP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH_ANGLE_KI = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROLL_ANGLE_KP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROLL_ANGLE_KI  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH_RATE_KP  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ROLL_RATE_KP   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_INT_LIM  = 3'd6;

  // sequencer step codes, consecutive, one pass per axis
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_ERR    = 4'd0;
  localparam logic [STEP_W-1:0] STEP_M_KP   = 4'd1;
  localparam logic [STEP_W-1:0] STEP_M_KI   = 4'd2;
  localparam logic [STEP_W-1:0] STEP_M_LP   = 4'd3;
  localparam logic [STEP_W-1:0] STEP_M_RAW  = 4'd4;
  localparam logic [STEP_W-1:0] STEP_FILT   = 4'd5;
  localparam logic [STEP_W-1:0] STEP_M_RATE = 4'd6;
  localparam logic [STEP_W-1:0] STEP_SUM    = 4'd7;
  localparam logic [STEP_W-1:0] STEP_M_HI   = 4'd8;
  localparam logic [STEP_W-1:0] STEP_M_LO   = 4'd9;
  localparam logic [STEP_W-1:0] STEP_DRIVE  = 4'd10;

  typedef struct packed {
    logic [GAIN_W-1:0]  pitch_angle_kp;
    logic [GAIN_W-1:0]  pitch_angle_ki;
    logic [GAIN_W-1:0]  roll_angle_kp;
    logic [GAIN_W-1:0]  roll_angle_ki;
    logic [GAIN_W-1:0]  pitch_rate_kp;
    logic [GAIN_W-1:0]  roll_rate_kp;
    logic [LIMIT_W-1:0] angle_integral_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] pitch_measured;
    logic signed [ANGLE_W-1:0] roll_measured;
    logic signed [ANGLE_W-1:0] pitch_target;
    logic signed [ANGLE_W-1:0] roll_target;
    logic signed [ANGLE_W-1:0] gyro_x_raw;
    logic signed [ANGLE_W-1:0] gyro_y_raw;
  } in_item_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] pitch_drive;
    logic signed [ANGLE_W-1:0] roll_drive;
    logic                      drive_saturated;
  } out_item_t;

  typedef struct packed {
    logic              load;
    logic              run;
    logic [STEP_W-1:0] step;
    logic              axis;     // 0: pitch, 1: roll
    logic              publish;
  } cmd_t;

endpackage

// ===== rtl/core/capu_if.sv =====
// ----------------------------------------------------------------------------
// capu_if
// Valid/ready channels for attitude samples and drive results.
// ----------------------------------------------------------------------------
interface capu_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [capu_pkg::ANGLE_W-1:0] pitch_measured;
  logic signed [capu_pkg::ANGLE_W-1:0] roll_measured;
  logic signed [capu_pkg::ANGLE_W-1:0] pitch_target;
  logic signed [capu_pkg::ANGLE_W-1:0] roll_target;
  logic signed [capu_pkg::ANGLE_W-1:0] gyro_x_raw;
  logic signed [capu_pkg::ANGLE_W-1:0] gyro_y_raw;

  modport source (
    output valid, pitch_measured, roll_measured, pitch_target, roll_target,
           gyro_x_raw, gyro_y_raw,
    input  ready
  );
  modport sink (
    input  valid, pitch_measured, roll_measured, pitch_target, roll_target,
           gyro_x_raw, gyro_y_raw,
    output ready
  );
endinterface

interface capu_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [capu_pkg::ANGLE_W-1:0] pitch_drive;
  logic signed [capu_pkg::ANGLE_W-1:0] roll_drive;
  logic                                drive_saturated;

  modport source (
    output valid, pitch_drive, roll_drive, drive_saturated,
    input  ready
  );
  modport sink (
    input  valid, pitch_drive, roll_drive, drive_saturated,
    output ready
  );
endinterface

// ===== rtl/core/capu_cfg.sv =====
// ----------------------------------------------------------------------------
// capu_cfg
// Gain and integral limit registers behind a plain write port.
// ----------------------------------------------------------------------------
module capu_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [capu_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [capu_pkg::GAIN_W-1:0]      cfg_data_i,
  output capu_pkg::cfg_t                   cfg_o
);
  import capu_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PITCH_ANGLE_KP: cfg_d.pitch_angle_kp = cfg_data_i;
        CFG_PITCH_ANGLE_KI: cfg_d.pitch_angle_ki = cfg_data_i;
        CFG_ROLL_ANGLE_KP:  cfg_d.roll_angle_kp  = cfg_data_i;
        CFG_ROLL_ANGLE_KI:  cfg_d.roll_angle_ki  = cfg_data_i;
        CFG_PITCH_RATE_KP:  cfg_d.pitch_rate_kp  = cfg_data_i;
        CFG_ROLL_RATE_KP:   cfg_d.roll_rate_kp   = cfg_data_i;
        CFG_ANGLE_INT_LIM:  cfg_d.angle_integral_limit = cfg_data_i[LIMIT_W-1:0];
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pitch_angle_kp       <= 24'd3276800;
      cfg_q.pitch_angle_ki       <= 24'd19661;
      cfg_q.roll_angle_kp        <= 24'd2424832;
      cfg_q.roll_angle_ki        <= 24'd14746;
      cfg_q.pitch_rate_kp        <= 24'd85197;
      cfg_q.roll_rate_kp         <= 24'd78643;
      cfg_q.angle_integral_limit <= 23'd307200;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/capu_dp.sv =====
// ----------------------------------------------------------------------------
// capu_dp
// Datapath: one shared signed multiplier with a product register, an
// accumulator, per-axis integral and filter state, and the result register.
// ----------------------------------------------------------------------------
module capu_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  capu_pkg::cmd_t      cmd_i,
  input  capu_pkg::cfg_t      cfg_i,
  input  capu_pkg::in_item_t  in_item_i,
  output capu_pkg::out_item_t out_item_o
);
  import capu_pkg::*;

  localparam logic signed [34:0] DRIVE_MAX = 35'sd32767;
  localparam logic signed [34:0] DRIVE_MIN = -35'sd32768;

  in_item_t                  in_q;
  logic signed [16:0]        err_q;
  logic signed [23:0]        sum_q   [2];
  logic signed [31:0]        filt_q  [2];
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [PROD_W-1:0]  acc_q;
  logic signed [32:0]        outer_q;
  logic signed [33:0]        e_q;
  logic signed [ANGLE_W-1:0] drv_q   [2];
  logic                      sat_q;
  out_item_t                 out_q;

  logic                      ax;
  logic signed [16:0]        err_c;
  logic signed [24:0]        s_c;
  logic signed [24:0]        lim_pos;
  logic signed [24:0]        lim_neg;
  logic signed [23:0]        s_clamp;
  logic [GAIN_W-1:0]         kp_c;
  logic [GAIN_W-1:0]         ki_c;
  logic [GAIN_W-1:0]         rkp_c;
  logic signed [ANGLE_W-1:0] raw_c;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [33:0]        f_w;
  logic signed [42:0]        a_w;
  logic signed [34:0]        q_w;
  logic signed [ANGLE_W-1:0] drv_c;
  logic                      clip_c;

  assign ax = cmd_i.axis;

  // pitch error is measured minus target, roll error the other way round
  always_comb begin
    if (!ax) begin
      err_c = {in_q.pitch_measured[ANGLE_W-1], in_q.pitch_measured}
            - {in_q.pitch_target[ANGLE_W-1], in_q.pitch_target};
    end else begin
      err_c = {in_q.roll_target[ANGLE_W-1], in_q.roll_target}
            - {in_q.roll_measured[ANGLE_W-1], in_q.roll_measured};
    end
  end

  assign kp_c  = ax ? cfg_i.roll_angle_kp : cfg_i.pitch_angle_kp;
  assign ki_c  = ax ? cfg_i.roll_angle_ki : cfg_i.pitch_angle_ki;
  assign rkp_c = ax ? cfg_i.roll_rate_kp  : cfg_i.pitch_rate_kp;
  assign raw_c = ax ? in_q.gyro_x_raw     : in_q.gyro_y_raw;

  // integral update with symmetric clamp
  assign s_c     = {sum_q[ax][23], sum_q[ax]} + {{8{err_c[16]}}, err_c};
  assign lim_pos = $signed({2'b00, cfg_i.angle_integral_limit});
  assign lim_neg = -lim_pos;

  always_comb begin
    if (s_c > lim_pos) begin
      s_clamp = lim_pos[23:0];
    end else if (s_c < lim_neg) begin
      s_clamp = lim_neg[23:0];
    end else begin
      s_clamp = s_c[23:0];
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.step)
      STEP_M_KP: begin
        mul_a = {{16{err_q[16]}}, err_q};
        mul_b = $signed({1'b0, kp_c});
      end
      STEP_M_KI: begin
        mul_a = {{9{sum_q[ax][23]}}, sum_q[ax]};
        mul_b = $signed({1'b0, ki_c});
      end
      STEP_M_LP: begin
        mul_a = {filt_q[ax][31], filt_q[ax]};
        mul_b = LP_OLD_W;
      end
      STEP_M_RAW: begin
        mul_a = {{17{raw_c[ANGLE_W-1]}}, raw_c};
        mul_b = LP_NEW_W;
      end
      STEP_M_RATE: begin
        mul_a = {filt_q[ax][31], filt_q[ax]};
        mul_b = RATE_SCALE;
      end
      STEP_M_HI: begin
        mul_a = {{15{e_q[33]}}, e_q[33:16]};
        mul_b = $signed({1'b0, rkp_c});
      end
      STEP_M_LO: begin
        mul_a = $signed({17'b0, e_q[15:0]});
        mul_b = $signed({1'b0, rkp_c});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // filter: floor(0.85 * old) plus the exact 0.15 * raw term
  assign f_w = {acc_q[OuterHi], acc_q[OuterHi:GainFracBits]}
             + {{4{prod_q[29]}}, prod_q[29:0]};

  // inner loop: kp*hi + floor(kp*lo / 2^16), then the remaining shift
  assign a_w = acc_q[42:0] + $signed({19'b0, prod_q[39:16]});
  assign q_w = a_w[42:8];

  always_comb begin
    clip_c = 1'b0;
    if (q_w > DRIVE_MAX) begin
      drv_c  = DRIVE_MAX[ANGLE_W-1:0];
      clip_c = 1'b1;
    end else if (q_w < DRIVE_MIN) begin
      drv_c  = DRIVE_MIN[ANGLE_W-1:0];
      clip_c = 1'b1;
    end else begin
      drv_c = q_w[ANGLE_W-1:0];
    end
  end

  // loop state, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q[0]  <= '0;
      sum_q[1]  <= '0;
      filt_q[0] <= '0;
      filt_q[1] <= '0;
    end else if (cmd_i.run) begin
      if (cmd_i.step == STEP_ERR) begin
        sum_q[ax] <= s_clamp;
      end
      if (cmd_i.step == STEP_FILT) begin
        filt_q[ax] <= f_w[31:0];
      end
    end
  end

  // working and payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_q  <= in_item_i;
      sat_q <= 1'b0;
    end
    if (cmd_i.run) begin
      prod_q <= mul_a * mul_b;
      case (cmd_i.step)
        STEP_ERR:   err_q   <= err_c;
        STEP_M_KI:  acc_q   <= prod_q;
        STEP_M_LP:  acc_q   <= acc_q + prod_q;
        STEP_M_RAW: begin
          outer_q <= acc_q[OuterHi:GainFracBits];
          acc_q   <= prod_q;
        end
        STEP_SUM:   e_q <= {outer_q[32], outer_q} + {{14{prod_q[43]}}, prod_q[43:24]};
        STEP_M_LO:  acc_q <= prod_q;
        STEP_DRIVE: begin
          drv_q[ax] <= drv_c;
          sat_q     <= sat_q | clip_c;
        end
        default: ;
      endcase
    end
    if (cmd_i.publish) begin
      out_q.pitch_drive     <= drv_q[0];
      out_q.roll_drive      <= drv_q[1];
      out_q.drive_saturated <= sat_q;
    end
  end

  assign out_item_o = out_q;

endmodule

// ===== rtl/core/capu_ctrl.sv =====
// ----------------------------------------------------------------------------
// capu_ctrl
// Sequencer: takes a sample, steps the datapath through both axes, then
// moves the result into the output register once that register is free.
// ----------------------------------------------------------------------------
module capu_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output capu_pkg::cmd_t cmd_o
);
  import capu_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_PUB  = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              axis_q, axis_d;
  logic              out_valid_q, out_valid_d;
  logic              out_free;

  assign in_ready_o = (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    axis_d  = axis_q;
    cmd_o   = '0;
    cmd_o.step = step_q;
    cmd_o.axis = axis_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_RUN;
          step_d     = STEP_ERR;
          axis_d     = 1'b0;
        end
      end
      ST_RUN: begin
        cmd_o.run = 1'b1;
        if (step_q == STEP_DRIVE) begin
          step_d = STEP_ERR;
          if (axis_q) begin
            axis_d  = 1'b0;
            state_d = ST_PUB;
          end else begin
            axis_d = 1'b1;
          end
        end else begin
          step_d = step_q + 4'd1;
        end
      end
      ST_PUB: begin
        // hold until the output register is free
        if (out_free) begin
          cmd_o.publish = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.publish) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= STEP_ERR;
      axis_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      axis_q      <= axis_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  a_start_pitch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=>
      (state_q == ST_RUN && step_q == STEP_ERR && !axis_q))
    else $error("sample transfer did not start the pitch pass");

  a_pub_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.publish |-> (!out_valid_q || out_ready_i))
    else $error("result published over a pending output");

  a_axis_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && step_q != STEP_DRIVE) |=> $stable(axis_q))
    else $error("axis changed in the middle of a pass");
`endif

endmodule

// ===== rtl/core/cascaded_two_axis_attitude_pid_unit.sv =====
// ----------------------------------------------------------------------------
// cascaded_two_axis_attitude_pid_unit
// Cascaded PI angle / P rate attitude controller for pitch and roll.
// ----------------------------------------------------------------------------
// Per sample the unit takes the input, runs 11 steps per axis on the shared
// multiplier, pitch first, then loads the output register once it is free.
// A new sample is accepted only after the last result has been loaded there.
// The output register holds a finished result while the next sample runs.
// Reset (async, active low) zeroes integrals and filters, loads the default
// gains and takes effect at once, with no clearing pass.
module cascaded_two_axis_attitude_pid_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  capu_in_if.sink                        in_i,
  capu_out_if.source                     out_o,
  input  logic                           cfg_we_i,
  input  logic [capu_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [capu_pkg::GAIN_W-1:0]    cfg_data_i
);
  import capu_pkg::*;

  cfg_t      cfg;
  cmd_t      cmd;
  in_item_t  in_item;
  out_item_t out_item;
  logic      in_ready;
  logic      out_valid;

  assign in_item.pitch_measured = in_i.pitch_measured;
  assign in_item.roll_measured  = in_i.roll_measured;
  assign in_item.pitch_target   = in_i.pitch_target;
  assign in_item.roll_target    = in_i.roll_target;
  assign in_item.gyro_x_raw     = in_i.gyro_x_raw;
  assign in_item.gyro_y_raw     = in_i.gyro_y_raw;

  capu_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  capu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  capu_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cfg_i      (cfg),
    .in_item_i  (in_item),
    .out_item_o (out_item)
  );

  assign in_i.ready            = in_ready;
  assign out_o.valid           = out_valid;
  assign out_o.pitch_drive     = out_item.pitch_drive;
  assign out_o.roll_drive      = out_item.roll_drive;
  assign out_o.drive_saturated = out_item.drive_saturated;

endmodule
